@@ rtl/sptq_pkg.sv @@
// shared types and constants for the sorted priority task queue
// used by sptq_cell and sorted_priority_task_queue_unit; no dependencies
package sptq_pkg;

  // default number of cells in the chain
  localparam int unsigned QueueDepthDef = 64;

  // field widths of one beat
  localparam int unsigned WordW = 64;
  localparam int unsigned PrioW = 16;
  localparam int unsigned OccW  = 7;
  localparam int unsigned InDataW  = 160;
  localparam int unsigned OutDataW = 152;

  // operation carried in in_tuser
  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_POP    = 1'b1
  } func_t;

  // result kind carried in out_tuser
  typedef enum logic [1:0] {
    ST_INSERTED   = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_NONE       = 2'd3
  } status_t;

  // one queued task
  typedef struct packed {
    logic [WordW-1:0]        handler;
    logic [WordW-1:0]        argument;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  // broadcast command seen by every cell
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t entry;
  } cell_cmd_t;

endpackage

@@ rtl/sptq_cell.sv @@
// one cell of the sorted queue chain: holds a single task and its valid bit
// depends on sptq_pkg
module sptq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  sptq_pkg::cell_cmd_t cmd_i,
  input  sptq_pkg::entry_t   left_entry_i,
  input  logic               left_valid_i,
  input  logic               left_take_i,
  input  sptq_pkg::entry_t   right_entry_i,
  input  logic               right_valid_i,
  output sptq_pkg::entry_t   entry_o,
  output logic               valid_o,
  output logic               take_o
);
  import sptq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;

  // this cell lies behind the insert point: empty or holding a larger number
  assign take_o = !valid_r || ($signed(entry_r.prio) > $signed(cmd_i.entry.prio));

  // insert shifts the tail right and drops the new task at the boundary,
  // pop shifts everything left
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (cmd_i.ins) begin
      if (take_o) begin
        if (left_take_i) begin
          entry_nxt = left_entry_i;
          valid_nxt = left_valid_i;
        end else begin
          entry_nxt = cmd_i.entry;
          valid_nxt = 1'b1;
        end
      end
    end else if (cmd_i.pop) begin
      entry_nxt = right_entry_i;
      valid_nxt = right_valid_i;
    end
  end

  // task payload
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign entry_o = entry_r;
  assign valid_o = valid_r;

endmodule

@@ rtl/sorted_priority_task_queue_unit.sv @@
// top level of the sorted priority task queue: a chain of sptq_cell
// plus request decode, occupancy count and the result register; uses sptq_pkg
//
//  channel  | direction | tuser            | tdata
//  ---------+-----------+------------------+---------------------------------------
//  in_      | slave     | func             | handler, argument, priority_req,
//           |           |                  | running_priority
//  out_     | master    | status           | out_handler, out_argument,
//           |           |                  | out_priority, occupancy
//
// one beat per cycle while in_tready is high; a beat's result appears in the next cycle.
// each cell compares its own priority against the broadcast request, so the
// insert or pop finishes in the same cycle for every queue depth.
// rst_n empties the queue at once; no clearing pass.
// in_tready stays high while the result register is empty or being taken;
// a held result blocks the input for as long as out_tready stays low.
module sorted_priority_task_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = sptq_pkg::QueueDepthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // handler [63:0], argument [127:64], priority_req [143:128],
  // running_priority [159:144]
  input  logic [sptq_pkg::InDataW-1:0]  in_tdata,
  // func [0]
  input  logic [0:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_handler [63:0], out_argument [127:64], out_priority [143:128],
  // occupancy [150:144], zero [151]
  output logic [sptq_pkg::OutDataW-1:0] out_tdata,
  // status [1:0]
  output logic [1:0]                    out_tuser
);
  import sptq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // request decode
  logic                    in_acc;
  func_t                   req_func;
  entry_t                  req_entry;
  logic signed [PrioW-1:0] req_running;

  assign in_acc              = in_tvalid && in_tready;
  assign req_func            = func_t'(in_tuser[0]);
  assign req_entry.handler   = in_tdata[WordW-1:0];
  assign req_entry.argument  = in_tdata[2*WordW-1:WordW];
  assign req_entry.prio      = $signed(in_tdata[2*WordW+PrioW-1:2*WordW]);
  assign req_running         = $signed(in_tdata[2*WordW+2*PrioW-1:2*WordW+PrioW]);

  // cell chain wiring
  entry_t                 cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_take;
  cell_cmd_t              cmd;

  logic [CntW-1:0] count_r, count_nxt;
  logic            full;
  logic            eligible;

  assign full     = (count_r == CntW'(QUEUE_DEPTH));
  assign eligible = cell_valid[0] && ($signed(cell_entry[0].prio) < req_running);

  assign cmd.ins   = in_acc && (req_func == FUNC_INSERT) && !full;
  assign cmd.pop   = in_acc && (req_func == FUNC_POP) && eligible;
  assign cmd.entry = req_entry;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_valid, left_take, right_valid;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_valid = 1'b0;
      assign left_take  = 1'b0;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_take  = cell_take[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
      assign right_valid = cell_valid[i+1];
    end

    sptq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd_i        (cmd),
      .left_entry_i (left_entry),
      .left_valid_i (left_valid),
      .left_take_i  (left_take),
      .right_entry_i(right_entry),
      .right_valid_i(right_valid),
      .entry_o      (cell_entry[i]),
      .valid_o      (cell_valid[i]),
      .take_o       (cell_take[i])
    );
  end

  // occupancy count
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CntW'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result register
  logic                    out_valid_r;
  status_t                 status_r, status_nxt;
  entry_t                  res_r, res_nxt;
  logic [OccW-1:0]         occ_r;

  assign in_tready = !out_valid_r || out_tready;

  always_comb begin
    res_nxt = '0;
    if (req_func == FUNC_INSERT) begin
      status_nxt = full ? ST_FULL : ST_INSERTED;
    end else if (eligible) begin
      status_nxt = ST_DISPATCHED;
      res_nxt    = cell_entry[0];
    end else begin
      status_nxt = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      occ_r    <= OccW'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {1'b0, occ_r, res_r.prio, res_r.argument, res_r.handler};

  // checks on the chain and the result register
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QUEUE_DEPTH))
    else $error("occupancy count above queue depth");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("cell valid bits disagree with occupancy count");

  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> cell_valid[0])
    else $error("head cell empty while queue holds tasks");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted request produced no result");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_DISPATCHED)) |-> (out_tdata[2*WordW+PrioW-1:0] == '0))
    else $error("non-dispatch result carries task data");

endmodule
